/* hdl/imh_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package imh_pkg;

    localparam int OP_BITS = 3;
    localparam int STATUS_BITS = 3;

    localparam logic [OP_BITS-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_BITS-1:0] OP_REMOVE_MAX = 3'd1;
    localparam logic [OP_BITS-1:0] OP_REMOVE_HANDLE = 3'd2;
    localparam logic [OP_BITS-1:0] OP_REMOVE_POS = 3'd3;
    localparam logic [OP_BITS-1:0] OP_CLEAR = 3'd4;

    localparam logic [STATUS_BITS-1:0] ST_OK = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_BAD = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_DUP = 3'd4;

    typedef enum logic [4:0] {
        S_CLR_SWEEP,
        S_IDLE,
        S_CHECK_RD,
        S_CHECK,
        S_REM_RD,
        S_REM,
        S_DN_RD,
        S_DN_CMP,
        S_DN_RD2,
        S_DN_DEC,
        S_UP_RD,
        S_UP_DEC,
        S_PLACE,
        S_TOP_RD,
        S_TOP,
        S_OUT,
        S_CLEAR
    } imh_state_t;

    // Datapath actions issued by the controller; only one is active per cycle.
    typedef enum logic [4:0] {
        A_NONE,
        A_CLR_SLOT,
        A_LATCH_IN,
        A_RD_CHECK,
        A_CHECK,
        A_RD_REM,
        A_REM,
        A_RD_CHILD_L,
        A_CMP_L,
        A_RD_CHILD_R,
        A_DN_DEC,
        A_RD_PARENT,
        A_UP_DEC,
        A_PLACE,
        A_RD_TOP,
        A_TOP,
        A_CLEAR_STEP
    } imh_action_t;

    typedef struct packed {
        imh_action_t action;
    } imh_cmd_t;

    // Branch outcomes computed in the datapath for the controller.
    typedef struct packed {
        logic chk_fail;     // CHECK: error or no-op, go report
        logic chk_insert;   // CHECK: insert, go rise
        logic chk_clear;    // CHECK: clear, go sweep
        logic rem_done;     // REM: error, or removed last slot; nothing to move
        logic dn_has_child; // DN: a left child exists
        logic dn_has_right; // DN: a right child exists
        logic dn_move;      // DN_DEC: child moved up, continue sinking
        logic dn_sank;      // DN_DEC stop: entry moved at least once
        logic up_has_par;   // UP: a parent exists
        logic up_move;      // UP_DEC: parent moved down
        logic sweep_done;   // sweeps finished
    } imh_status_t;

endpackage
`default_nettype wire

/* hdl/imh_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module imh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* hdl/imh_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module imh_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    input  wire imh_pkg::imh_status_t sts,
    output imh_pkg::imh_cmd_t         cmd
);
    import imh_pkg::*;

    imh_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR_SWEEP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLR_SWEEP: if (sts.sweep_done) state_next = S_IDLE;
            S_IDLE:      if (in_valid) state_next = S_CHECK_RD;
            S_CHECK_RD:  state_next = S_CHECK;
            S_CHECK:
            begin
                if (sts.chk_fail) state_next = S_TOP_RD;
                else if (sts.chk_clear) state_next = S_CLEAR;
                else if (sts.chk_insert) state_next = S_UP_RD;
                else state_next = S_REM_RD;
            end
            S_REM_RD:    state_next = S_REM;
            S_REM:       state_next = sts.rem_done ? S_TOP_RD : S_DN_RD;
            S_DN_RD:     state_next = sts.dn_has_child ? S_DN_CMP : S_UP_RD;
            S_DN_CMP:    state_next = sts.dn_has_right ? S_DN_RD2 : S_DN_DEC;
            S_DN_RD2:    state_next = S_DN_DEC;
            S_DN_DEC:
            begin
                if (sts.dn_move) state_next = S_DN_RD;
                else if (sts.dn_sank) state_next = S_PLACE;
                else state_next = S_UP_RD;
            end
            S_UP_RD:     state_next = sts.up_has_par ? S_UP_DEC : S_PLACE;
            S_UP_DEC:    state_next = sts.up_move ? S_UP_RD : S_PLACE;
            S_PLACE:     state_next = S_TOP_RD;
            S_TOP_RD:    state_next = S_TOP;
            S_TOP:       state_next = S_OUT;
            S_OUT:       if (out_ready) state_next = S_IDLE;
            S_CLEAR:     if (sts.sweep_done) state_next = S_TOP_RD;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        out_valid = 1'b0;
        cmd.action = A_NONE;
        case (state_reg)
            S_CLR_SWEEP: cmd.action = A_CLR_SLOT;
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) cmd.action = A_LATCH_IN;
            end
            S_CHECK_RD:  cmd.action = A_RD_CHECK;
            S_CHECK:     cmd.action = A_CHECK;
            S_REM_RD:    cmd.action = A_RD_REM;
            S_REM:       cmd.action = A_REM;
            S_DN_RD:     cmd.action = A_RD_CHILD_L;
            S_DN_CMP:    cmd.action = A_CMP_L;
            S_DN_RD2:    cmd.action = A_RD_CHILD_R;
            S_DN_DEC:    cmd.action = A_DN_DEC;
            S_UP_RD:     cmd.action = A_RD_PARENT;
            S_UP_DEC:    cmd.action = A_UP_DEC;
            S_PLACE:     cmd.action = A_PLACE;
            S_TOP_RD:    cmd.action = A_RD_TOP;
            S_TOP:       cmd.action = A_TOP;
            S_OUT:       out_valid = 1'b1;
            S_CLEAR:     cmd.action = A_CLEAR_STEP;
            default:     cmd.action = A_NONE;
        endcase
    end
endmodule
`default_nettype wire

/* hdl/imh_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
module imh_dp #(
    parameter int HEAP_SLOTS = 1024,
    parameter int KEY_BITS = 32,
    parameter int HANDLE_COUNT = 1024
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire imh_pkg::imh_cmd_t      cmd,
    output imh_pkg::imh_status_t        sts,
    input  wire logic [2:0]             opcode,
    input  wire logic [31:0]            entry_key,
    input  wire logic [9:0]             entry_handle,
    input  wire logic [9:0]             heap_position,
    output logic [2:0]                  status,
    output logic                        removed_valid,
    output logic [31:0]                 removed_key,
    output logic [9:0]                  removed_handle,
    output logic                        top_valid,
    output logic [31:0]                 top_key,
    output logic [9:0]                  top_handle,
    output logic [9:0]                  entry_count,
    output logic                        heap_full
);
    import imh_pkg::*;

    localparam int PB = $clog2(HEAP_SLOTS);
    localparam int HB = $clog2(HANDLE_COUNT);
    localparam int KB = KEY_BITS;
    // Position arithmetic needs one spare bit for 2*at+1.
    localparam int PW = PB + 1;
    localparam logic [PW-1:0] FULL_AT = PW'(HEAP_SLOTS - 1);

    // Heap key, heap handle and slot-of-handle memories.
    logic          k_we;
    logic [PB-1:0] k_wa, k_ra;
    logic [KB-1:0] k_wd, k_rd;
    logic          h_we;
    logic [PB-1:0] h_wa, h_ra;
    logic [HB-1:0] h_wd, h_rd;
    logic          s_we;
    logic [HB-1:0] s_wa, s_ra;
    logic [PB-1:0] s_wd, s_rd;

    imh_ram #(.WIDTH(KB), .DEPTH(HEAP_SLOTS)) u_key (
        .clk(clk), .we(k_we), .waddr(k_wa), .wdata(k_wd), .raddr(k_ra), .rdata(k_rd));
    imh_ram #(.WIDTH(HB), .DEPTH(HEAP_SLOTS)) u_hnd (
        .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));
    imh_ram #(.WIDTH(PB), .DEPTH(HANDLE_COUNT)) u_slot (
        .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));

    logic [2:0]    op_reg, op_next;
    logic [KB-1:0] key_reg, key_next;       // entry being placed
    logic [HB-1:0] hnd_reg, hnd_next;
    logic          hin_ok_reg, hin_ok_next;
    logic [9:0]    pin_reg, pin_next;
    logic [PW-1:0] cnt_reg, cnt_next;
    logic [PW-1:0] at_reg, at_next;         // current hole
    logic [PW-1:0] pos_reg, pos_next;       // freed slot of a removal
    logic [PW-1:0] ch_reg, ch_next;         // chosen child
    logic [KB-1:0] ckey_reg, ckey_next;
    logic [HB-1:0] chnd_reg, chnd_next;
    logic [HB:0]   sweep_reg, sweep_next;
    logic [2:0]    st_reg, st_next;
    logic          rv_reg, rv_next;
    logic [KB-1:0] rk_reg, rk_next;
    logic [HB-1:0] rh_reg, rh_next;
    logic [KB-1:0] tk_reg, tk_next;
    logic [HB-1:0] th_reg, th_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            sweep_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            sweep_reg <= sweep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        key_reg <= key_next;
        hnd_reg <= hnd_next;
        hin_ok_reg <= hin_ok_next;
        pin_reg <= pin_next;
        at_reg <= at_next;
        pos_reg <= pos_next;
        ch_reg <= ch_next;
        ckey_reg <= ckey_next;
        chnd_reg <= chnd_next;
        st_reg <= st_next;
        rv_reg <= rv_next;
        rk_reg <= rk_next;
        rh_reg <= rh_next;
        tk_reg <= tk_next;
        th_reg <= th_next;
    end

    logic [PW-1:0] lc, rc, par, slot_p;

    always_comb
    begin
        lc = {at_reg[PW-2:0], 1'b0};
        rc = {at_reg[PW-2:0], 1'b1};
        par = {1'b0, at_reg[PW-1:1]};
        slot_p = {1'b0, s_rd};
    end

    always_comb
    begin
        op_next = op_reg;
        key_next = key_reg;
        hnd_next = hnd_reg;
        hin_ok_next = hin_ok_reg;
        pin_next = pin_reg;
        cnt_next = cnt_reg;
        at_next = at_reg;
        pos_next = pos_reg;
        ch_next = ch_reg;
        ckey_next = ckey_reg;
        chnd_next = chnd_reg;
        sweep_next = sweep_reg;
        st_next = st_reg;
        rv_next = rv_reg;
        rk_next = rk_reg;
        rh_next = rh_reg;
        tk_next = tk_reg;
        th_next = th_reg;
        k_we = 1'b0; k_wa = '0; k_wd = key_reg; k_ra = '0;
        h_we = 1'b0; h_wa = '0; h_wd = hnd_reg; h_ra = '0;
        s_we = 1'b0; s_wa = hnd_reg; s_wd = '0; s_ra = hnd_reg;
        sts = '0;

        case (cmd.action)
            A_CLR_SLOT:
            begin
                s_we = 1'b1;
                s_wa = sweep_reg[HB-1:0];
                s_wd = '0;
                sts.sweep_done = (sweep_reg == (HB+1)'(HANDLE_COUNT - 1));
                sweep_next = sts.sweep_done ? '0 : sweep_reg + 1'b1;
            end
            A_LATCH_IN:
            begin
                op_next = opcode;
                key_next = KB'(entry_key);
                hin_ok_next = (32'(entry_handle) < 32'(HANDLE_COUNT));
                hnd_next = HB'(entry_handle);
                pin_next = heap_position;
                rv_next = 1'b0;
                rk_next = '0;
                rh_next = '0;
                st_next = ST_OK;
            end
            A_RD_CHECK:
            begin
                s_ra = hnd_reg;
            end
            A_CHECK:
            begin
                // Heap key and handle reads of the freed slot are issued in the same cycle;
                // for opcode 2 the address comes off the slot read result below.
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (cnt_reg >= FULL_AT) st_next = ST_FULL;
                        else if (!hin_ok_reg) st_next = ST_BAD;
                        else if (slot_p != '0) st_next = ST_DUP;
                        if (cnt_reg < FULL_AT && hin_ok_reg && slot_p == '0)
                        begin
                            sts.chk_insert = 1'b1;
                            cnt_next = cnt_reg + 1'b1;
                            at_next = cnt_reg + 1'b1;
                        end
                        else
                        begin
                            sts.chk_fail = 1'b1;
                        end
                    end
                    OP_REMOVE_MAX, OP_REMOVE_HANDLE, OP_REMOVE_POS:
                    begin
                        if (cnt_reg == '0)
                        begin
                            st_next = ST_EMPTY;
                            sts.chk_fail = 1'b1;
                        end
                        else if (op_reg == OP_REMOVE_MAX)
                        begin
                            pos_next = PW'(1);
                        end
                        else if (op_reg == OP_REMOVE_HANDLE)
                        begin
                            if (!hin_ok_reg)
                            begin
                                st_next = ST_BAD;
                                sts.chk_fail = 1'b1;
                            end
                            pos_next = slot_p;
                        end
                        else
                        begin
                            if (pin_reg == '0 || PW'(pin_reg) > cnt_reg ||
                                (PW > 10 ? 1'b0 : (pin_reg >> (PW > 10 ? 0 : PW)) != '0))
                            begin
                                st_next = ST_BAD;
                                sts.chk_fail = 1'b1;
                            end
                            pos_next = PW'(pin_reg);
                        end
                    end
                    OP_CLEAR:
                    begin
                        sts.chk_clear = 1'b1;
                        sweep_next = '0;
                        at_next = PW'(1);
                    end
                    default:
                    begin
                        sts.chk_fail = 1'b1;
                    end
                endcase
                h_ra = pos_next[PB-1:0];
                k_ra = pos_next[PB-1:0];
            end
            A_RD_REM:
            begin
                // Key and handle of the freed slot arrive now; fetch the last entry.
                rk_next = k_rd;
                rh_next = h_rd;
                k_ra = cnt_reg[PB-1:0];
                h_ra = cnt_reg[PB-1:0];
            end
            A_REM:
            begin
                if (op_reg == OP_REMOVE_HANDLE && (pos_reg == '0 || pos_reg > cnt_reg ||
                    rh_reg != hnd_reg))
                begin
                    st_next = ST_BAD;
                    sts.rem_done = 1'b1;
                end
                else
                begin
                    rv_next = 1'b1;
                    key_next = k_rd;
                    hnd_next = h_rd;
                    cnt_next = cnt_reg - 1'b1;
                    s_we = 1'b1;
                    s_wa = rh_reg;
                    s_wd = '0;
                    at_next = pos_reg;
                    sts.rem_done = (pos_reg > cnt_reg - 1'b1);
                end
            end
            A_RD_CHILD_L:
            begin
                sts.dn_has_child = (lc <= cnt_reg) && !at_reg[PW-1];
                k_ra = lc[PB-1:0];
                h_ra = lc[PB-1:0];
                if (!sts.dn_has_child)
                begin
                    // With no child, go on to the rise phase, which rises only if nothing sank.
                    at_next = at_reg;
                end
            end
            A_CMP_L:
            begin
                ckey_next = k_rd;
                chnd_next = h_rd;
                ch_next = lc;
                sts.dn_has_right = (lc != cnt_reg);
                k_ra = rc[PB-1:0];
                h_ra = rc[PB-1:0];
            end
            A_RD_CHILD_R:
            begin
                if (k_rd > ckey_reg)
                begin
                    ckey_next = k_rd;
                    chnd_next = h_rd;
                    ch_next = rc;
                end
            end
            A_DN_DEC:
            begin
                if (key_reg < ckey_reg)
                begin
                    sts.dn_move = 1'b1;
                    k_we = 1'b1; k_wa = at_reg[PB-1:0]; k_wd = ckey_reg;
                    h_we = 1'b1; h_wa = at_reg[PB-1:0]; h_wd = chnd_reg;
                    s_we = 1'b1; s_wa = chnd_reg; s_wd = at_reg[PB-1:0];
                    at_next = ch_reg;
                end
                sts.dn_sank = (at_reg != pos_reg);
            end
            A_RD_PARENT:
            begin
                sts.up_has_par = (at_reg > PW'(1)) && (at_reg == pos_reg ||
                                 op_reg == OP_INSERT);
                k_ra = par[PB-1:0];
                h_ra = par[PB-1:0];
            end
            A_UP_DEC:
            begin
                if (k_rd < key_reg)
                begin
                    sts.up_move = 1'b1;
                    k_we = 1'b1; k_wa = at_reg[PB-1:0]; k_wd = k_rd;
                    h_we = 1'b1; h_wa = at_reg[PB-1:0]; h_wd = h_rd;
                    s_we = 1'b1; s_wa = h_rd; s_wd = at_reg[PB-1:0];
                    at_next = par;
                    pos_next = par;
                end
            end
            A_PLACE:
            begin
                k_we = 1'b1; k_wa = at_reg[PB-1:0]; k_wd = key_reg;
                h_we = 1'b1; h_wa = at_reg[PB-1:0]; h_wd = hnd_reg;
                s_we = 1'b1; s_wa = hnd_reg; s_wd = at_reg[PB-1:0];
            end
            A_RD_TOP:
            begin
                k_ra = PB'(1);
                h_ra = PB'(1);
            end
            A_TOP:
            begin
                tk_next = k_rd;
                th_next = h_rd;
            end
            A_CLEAR_STEP:
            begin
                // For each slot, read the handle, then zero its slot entry.
                if (sweep_reg[0] == 1'b0)
                begin
                    h_ra = at_reg[PB-1:0];
                    sts.sweep_done = (at_reg > cnt_reg);
                    if (sts.sweep_done)
                    begin
                        cnt_next = '0;
                        sweep_next = '0;
                    end
                    else
                    begin
                        sweep_next = sweep_reg + 1'b1;
                    end
                end
                else
                begin
                    s_we = 1'b1; s_wa = h_rd; s_wd = '0;
                    at_next = at_reg + 1'b1;
                    sweep_next = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        status = st_reg;
        removed_valid = rv_reg;
        removed_key = rv_reg ? 32'(rk_reg) : '0;
        removed_handle = rv_reg ? 10'(rh_reg) : '0;
        top_valid = (cnt_reg != '0);
        top_key = top_valid ? 32'(tk_reg) : '0;
        top_handle = top_valid ? 10'(th_reg) : '0;
        entry_count = 10'(cnt_reg);
        heap_full = (cnt_reg >= FULL_AT);
    end
endmodule
`default_nettype wire

/* hdl/indexed_max_heap.sv */
`timescale 1ns / 1ps
`default_nettype none
// Indexed binary max-heap of (key, handle) entries.
// Input channel: in_valid/in_ready carry one beat of opcode, entry_key,
// entry_handle and heap_position. Output channel: out_valid/out_ready carry
// one result beat per input beat: status, removed entry, top entry, count
// and the full flag.
// One item is in flight at a time. An error or an unused opcode goes straight
// to the report. An insert raises the new entry toward the root. A removal
// that moves the last entry into the freed slot sinks it, or raises it if
// it did not sink. A clear zeroes the slot entry of each stored entry.
// After reset the slot-of-handle memory is swept to zero, one handle per
// cycle, while in_ready stays low.
// A result beat waits in its output registers until out_ready is high; no
// new item is taken during that time.
module indexed_max_heap #(
    parameter int HEAP_SLOTS = 1024,
    parameter int KEY_BITS = 32,
    parameter int HANDLE_COUNT = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  opcode,
    input  wire logic [31:0] entry_key,
    input  wire logic [9:0]  entry_handle,
    input  wire logic [9:0]  heap_position,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic             removed_valid,
    output logic [31:0]      removed_key,
    output logic [9:0]       removed_handle,
    output logic             top_valid,
    output logic [31:0]      top_key,
    output logic [9:0]       top_handle,
    output logic [9:0]       entry_count,
    output logic             heap_full
);
    import imh_pkg::*;

    imh_cmd_t    cmd;
    imh_status_t sts;

    imh_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd));

    imh_dp #(.HEAP_SLOTS(HEAP_SLOTS), .KEY_BITS(KEY_BITS),
             .HANDLE_COUNT(HANDLE_COUNT)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .opcode(opcode), .entry_key(entry_key), .entry_handle(entry_handle),
        .heap_position(heap_position), .status(status),
        .removed_valid(removed_valid), .removed_key(removed_key),
        .removed_handle(removed_handle), .top_valid(top_valid),
        .top_key(top_key), .top_handle(top_handle),
        .entry_count(entry_count), .heap_full(heap_full));

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output side active together");
    a_rem_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && removed_valid |-> status == ST_OK)
        else $error("removal reported with error status");
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !top_valid |-> entry_count == '0)
        else $error("top flag disagrees with count");
endmodule
`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps
module tb;
    import imh_pkg::*;

    localparam int SLOTS = 1024;
    localparam int HANDLES = 1024;
    localparam logic [2:0] OP_SPARE = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  opcode = '0;
    logic [31:0] entry_key = '0;
    logic [9:0]  entry_handle = '0;
    logic [9:0]  heap_position = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic        removed_valid;
    logic [31:0] removed_key;
    logic [9:0]  removed_handle;
    logic        top_valid;
    logic [31:0] top_key;
    logic [9:0]  top_handle;
    logic [9:0]  entry_count;
    logic        heap_full;

    indexed_max_heap u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .entry_key(entry_key),
        .entry_handle(entry_handle), .heap_position(heap_position),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .removed_valid(removed_valid),
        .removed_key(removed_key), .removed_handle(removed_handle),
        .top_valid(top_valid), .top_key(top_key), .top_handle(top_handle),
        .entry_count(entry_count), .heap_full(heap_full)
    );

    always #5 clk = ~clk;

    typedef struct packed {
        logic [2:0]  st;
        logic        rem_v;
        logic [31:0] rem_key;
        logic [9:0]  rem_handle;
        logic        top_v;
        logic [31:0] top_k;
        logic [9:0]  top_h;
        logic [9:0]  cnt;
        logic        full;
    } heap_result_t;

    typedef struct {
        logic [2:0]   op;
        logic [31:0]  key;
        logic [9:0]   handle;
        logic [9:0]   pos;
        bit           typed;
        heap_result_t want;
    } stim_row_t;

    // Shadow heap.
    logic [31:0] shadow_key [SLOTS];
    logic [9:0]  shadow_handle [SLOTS];
    logic [9:0]  shadow_slot [HANDLES];
    int          shadow_count;

    heap_result_t pending_results[$];
    bit           typed_flags[$];
    heap_result_t typed_wants[$];
    bit           beat_typed = 1'b0;
    heap_result_t beat_want = '0;
    int errors = 0;
    int results_seen = 0;
    int removals_seen = 0;
    int max_depth = 0;
    bit calm = 1'b0;

    function automatic void place_entry(int p, logic [31:0] k, logic [9:0] h);
        shadow_key[p] = k;
        shadow_handle[p] = h;
        shadow_slot[h] = p[9:0];
    endfunction

    function automatic void sift_up(int p, logic [31:0] k, logic [9:0] h);
        while (p > 1 && shadow_key[p >> 1] < k)
        begin
            place_entry(p, shadow_key[p >> 1], shadow_handle[p >> 1]);
            p = p >> 1;
        end
        place_entry(p, k, h);
    endfunction

    function automatic void take_slot(int p, output logic [31:0] rk,
                                      output logic [9:0] rh);
        logic [31:0] lk;
        logic [9:0]  lh;
        int at;
        int c;
        lk = shadow_key[shadow_count];
        lh = shadow_handle[shadow_count];
        at = p;
        rk = shadow_key[p];
        rh = shadow_handle[p];
        shadow_count--;
        shadow_slot[rh] = '0;
        if (p > shadow_count) return;
        while ((at << 1) <= shadow_count)
        begin
            c = at << 1;
            if (c != shadow_count && shadow_key[c + 1] > shadow_key[c]) c++;
            if (lk < shadow_key[c])
            begin
                place_entry(at, shadow_key[c], shadow_handle[c]);
                at = c;
            end
            else break;
        end
        if (at == p) sift_up(p, lk, lh);
        else place_entry(at, lk, lh);
    endfunction

    function automatic heap_result_t heap_apply(logic [2:0] op, logic [31:0] k,
                                                logic [9:0] h, logic [9:0] pos);
        heap_result_t r;
        int p;
        r = '0;
        r.st = ST_OK;
        case (op)
            OP_INSERT:
            begin
                if (shadow_count >= SLOTS - 1) r.st = ST_FULL;
                else if (shadow_slot[h] != 0) r.st = ST_DUP;
                else
                begin
                    shadow_count++;
                    sift_up(shadow_count, k, h);
                end
            end
            OP_REMOVE_MAX:
            begin
                if (shadow_count == 0) r.st = ST_EMPTY;
                else
                begin
                    take_slot(1, r.rem_key, r.rem_handle);
                    r.rem_v = 1'b1;
                end
            end
            OP_REMOVE_HANDLE:
            begin
                p = shadow_slot[h];
                if (shadow_count == 0) r.st = ST_EMPTY;
                else if (p == 0 || p > shadow_count || shadow_handle[p] != h)
                    r.st = ST_BAD;
                else
                begin
                    take_slot(p, r.rem_key, r.rem_handle);
                    r.rem_v = 1'b1;
                end
            end
            OP_REMOVE_POS:
            begin
                if (shadow_count == 0) r.st = ST_EMPTY;
                else if (pos < 1 || pos > shadow_count) r.st = ST_BAD;
                else
                begin
                    take_slot(pos, r.rem_key, r.rem_handle);
                    r.rem_v = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                for (int i = 1; i <= shadow_count; i++)
                    shadow_slot[shadow_handle[i]] = '0;
                shadow_count = 0;
            end
            default: ;
        endcase
        if (shadow_count > 0)
        begin
            r.top_v = 1'b1;
            r.top_k = shadow_key[1];
            r.top_h = shadow_handle[1];
        end
        r.cnt = shadow_count[9:0];
        r.full = (shadow_count >= SLOTS - 1);
        if (shadow_count > max_depth) max_depth = shadow_count;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH result %0d %s: got %0h, expected %0h", results_seen,
                 what, got, want);
        errors++;
    endtask

    task automatic compare_result(string tag, heap_result_t w);
        if (status !== w.st)
            report_mismatch({tag, " status"}, 64'(status), 64'(w.st));
        if (removed_valid !== w.rem_v)
            report_mismatch({tag, " removed_valid"}, 64'(removed_valid), 64'(w.rem_v));
        if (removed_key !== w.rem_key)
            report_mismatch({tag, " removed_key"}, 64'(removed_key), 64'(w.rem_key));
        if (removed_handle !== w.rem_handle)
            report_mismatch({tag, " removed_handle"}, 64'(removed_handle),
                            64'(w.rem_handle));
        if (top_valid !== w.top_v)
            report_mismatch({tag, " top_valid"}, 64'(top_valid), 64'(w.top_v));
        if (top_key !== w.top_k)
            report_mismatch({tag, " top_key"}, 64'(top_key), 64'(w.top_k));
        if (top_handle !== w.top_h)
            report_mismatch({tag, " top_handle"}, 64'(top_handle), 64'(w.top_h));
        if (entry_count !== w.cnt)
            report_mismatch({tag, " entry_count"}, 64'(entry_count), 64'(w.cnt));
        if (heap_full !== w.full)
            report_mismatch({tag, " heap_full"}, 64'(heap_full), 64'(w.full));
    endtask

    task automatic send_beat(logic [2:0] op, logic [31:0] k, logic [9:0] h,
                             logic [9:0] pos, bit typed = 1'b0,
                             heap_result_t want = '0);
        while (!calm && $urandom_range(99) < 21)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        entry_key <= k;
        entry_handle <= h;
        heap_position <= pos;
        beat_typed <= typed;
        beat_want <= want;
        do @(posedge clk); while (!in_ready);
    endtask

    // Expectations are queued when the input beat is accepted.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            pending_results.push_back(heap_apply(opcode, entry_key, entry_handle,
                                                 heap_position));
            typed_flags.push_back(beat_typed);
            typed_wants.push_back(beat_want);
        end
    end

    always @(posedge clk)
    begin
        heap_result_t w;
        heap_result_t tw;
        bit tf;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    report_mismatch("with nothing pending", 64'(1), 64'(0));
                end
                else
                begin
                    w = pending_results.pop_front();
                    tf = typed_flags.pop_front();
                    tw = typed_wants.pop_front();
                    if (removed_valid) removals_seen++;
                    compare_result("predicted", w);
                    // Rows with a typed result are also compared directly.
                    if (tf) compare_result("table", tw);
                end
            end
            out_ready <= calm || ($urandom_range(99) >= 21);
        end
    end

    stim_row_t rows[$];

    function automatic stim_row_t mk(logic [2:0] op, logic [31:0] k, logic [9:0] h,
                                     logic [9:0] pos);
        stim_row_t s;
        s.op = op; s.key = k; s.handle = h; s.pos = pos;
        s.typed = 1'b0; s.want = '0;
        return s;
    endfunction

    function automatic stim_row_t mk_err(logic [2:0] op, logic [9:0] h,
                                         logic [9:0] pos, logic [2:0] st);
        stim_row_t s;
        s = mk(op, 32'h0, h, pos);
        s.typed = 1'b1;
        s.want.st = st;
        return s;
    endfunction

    task automatic run_rows();
        foreach (rows[i])
        begin
            send_beat(rows[i].op, rows[i].key, rows[i].handle, rows[i].pos,
                      rows[i].typed, rows[i].want);
        end
    endtask

    task automatic random_sequence(int n);
        logic [9:0] h;
        int p;
        int roll;
        for (int i = 0; i < n; i++)
        begin
            roll = $urandom_range(99);
            h = shadow_count > 0 && $urandom_range(3) != 0 ?
                shadow_handle[$urandom_range(shadow_count, 1)] : 10'($urandom);
            if (shadow_count > 0) p = $urandom_range(shadow_count, 1);
            else p = $urandom_range(3);
            if (roll < 45)
                send_beat(OP_INSERT, $urandom_range(3) == 0 ? $urandom_range(15) : $urandom,
                          $urandom_range(3) == 0 ? h : 10'($urandom), 10'($urandom));
            else if (roll < 62) send_beat(OP_REMOVE_MAX, $urandom, h, 10'($urandom));
            else if (roll < 78) send_beat(OP_REMOVE_HANDLE, $urandom, h, 10'($urandom));
            else if (roll < 93)
                send_beat(OP_REMOVE_POS, $urandom, 10'($urandom),
                          $urandom_range(7) == 0 ? 10'($urandom) : p[9:0]);
            else if (roll < 96) send_beat(OP_CLEAR, $urandom, h, 10'($urandom));
            else send_beat(3'($urandom_range(7, 5)), $urandom, 10'($urandom),
                           10'($urandom));
        end
    endtask

    initial
    begin
        int guard;
        for (int i = 0; i < HANDLES; i++) shadow_slot[i] = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            shadow_key[i] = '0;
            shadow_handle[i] = '0;
        end
        shadow_count = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        rows.push_back(mk_err(OP_REMOVE_MAX, 10'd0, 10'd0, ST_EMPTY));
        rows.push_back(mk_err(OP_REMOVE_HANDLE, 10'd1023, 10'd0, ST_EMPTY));
        rows.push_back(mk_err(OP_REMOVE_POS, 10'd0, 10'd1, ST_EMPTY));
        rows.push_back(mk_err(OP_CLEAR, 10'd0, 10'd0, ST_OK));
        rows.push_back(mk_err(OP_SPARE, 10'h3ff, 10'h3ff, ST_OK));
        rows.push_back(mk(OP_INSERT, 32'hffff_ffff, 10'd1023, 10'h3ff));
        rows.push_back(mk(OP_INSERT, 32'h0, 10'd0, 10'd0));
        rows.push_back(mk(OP_INSERT, 32'h5555_aaaa, 10'h2aa, 10'h155));
        rows.push_back(mk(OP_INSERT, 32'haaaa_5555, 10'h155, 10'h2aa));
        rows.push_back(mk(OP_INSERT, 32'h1234, 10'd0, 10'd0));
        rows.push_back(mk(OP_INSERT, 32'h8000_0000, 10'd7, 10'd0));
        rows.push_back(mk(OP_INSERT, 32'h7fff_ffff, 10'd9, 10'd0));
        rows.push_back(mk(OP_REMOVE_POS, 32'h0, 10'd0, 10'd0));
        rows.push_back(mk(OP_REMOVE_POS, 32'h0, 10'd0, 10'd1023));
        rows.push_back(mk(OP_REMOVE_HANDLE, 32'h0, 10'd500, 10'd0));
        rows.push_back(mk(OP_REMOVE_POS, 32'h0, 10'd0, 10'd2));
        rows.push_back(mk(OP_REMOVE_HANDLE, 32'h0, 10'h155, 10'd0));
        rows.push_back(mk(OP_REMOVE_MAX, 32'h0, 10'd0, 10'd0));
        rows.push_back(mk(OP_INSERT, 32'h10, 10'd20, 10'd0));
        rows.push_back(mk(OP_CLEAR, 32'h0, 10'd0, 10'd0));
        rows.push_back(mk(OP_INSERT, 32'h10, 10'd1023, 10'd0));
        rows.push_back(mk(OP_REMOVE_MAX, 32'h0, 10'd0, 10'd0));
        run_rows();

        random_sequence(80);
        // Offer every absent handle with no idling; the heap fills and the last
        // offer reports full.
        calm = 1'b1;
        for (int i = 0; i < HANDLES; i++)
        begin
            if (shadow_slot[i] == '0) send_beat(OP_INSERT, $urandom, 10'(i), 10'd0);
        end
        calm = 1'b0;
        for (int i = 0; i < 20; i++) send_beat(OP_REMOVE_POS, $urandom, 10'd0,
                                               10'($urandom_range(shadow_count, 1)));
        random_sequence(40);
        send_beat(OP_CLEAR, 32'h0, 10'd0, 10'd0);
        random_sequence(60);
        in_valid <= 1'b0;

        guard = 0;
        while (pending_results.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (200) @(posedge clk);
        $display("Covered %0d results, %0d removals, peak heap depth %0d.",
                 results_seen, removals_seen, max_depth);
        if (errors == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Timeout after %0d results", results_seen);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
